// File: rtl/ipa2t_pkg.sv
`default_nettype none

package ipa2t_pkg;

  // ASCII codes used in the text
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;
  localparam logic [6:0] HEX_ALPHA_BASE = 7'h57;  // 'a' - 10

  localparam int unsigned V6_WIDTH = 128;
  localparam int unsigned V4_WIDTH = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_V6_WORD,
    S_V6_SKIP,
    S_V6_NIB,
    S_V4_CONV,
    S_V4_DIG,
    S_V4_DOT
  } state_t;

  // One character beat from the sequencer
  typedef struct packed {
    logic       valid;
    logic [6:0] code;
    logic       last;
  } char_beat_t;

  // Control of the bit-serial binary to BCD unit
  typedef struct packed {
    logic shift;       // take one binary bit
    logic first;       // first bit of an octet: start from zero
    logic bit_in;
    logic next_digit;  // move the next BCD digit to the top
  } dd_ctrl_t;

  // Lowercase hex character for one nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      return CHAR_ZERO + n7;
    end else begin
      return HEX_ALPHA_BASE + n7;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/ipa2t_in_if.sv
`default_nettype none

interface ipa2t_in_if;
  logic        valid;
  logic        ready;
  logic        is_ipv6;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [31:0] ipv4_addr;

  modport source (output valid, is_ipv6, addr_hi, addr_lo, ipv4_addr, input ready);
  modport sink   (input valid, is_ipv6, addr_hi, addr_lo, ipv4_addr, output ready);
endinterface

`default_nettype wire

// File: rtl/ipa2t_out_if.sv
`default_nettype none

interface ipa2t_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

`default_nettype wire

// File: rtl/ip_address_to_text.sv
`default_nettype none

// Channel  Dir  Beat payload                                 Accepted when
// in_ch    in   is_ipv6, addr_hi, addr_lo, ipv4_addr          valid && ready
// out_ch   out  char_code (ASCII), last (final char of text)  valid && ready
//
// IPv6: a word step per word and a step per nibble, a zero run skipped one word
//   per cycle while the output is not stalled; the accept step comes first.
// IPv4: per octet bit-serial binary to BCD, the digit steps and a dot step
//   (none after the last octet), after the accept step.
// Reset (synchronous) returns the sequencer to idle and empties the output stage.
// A stalled output freezes the sequencer; the next address is taken as soon
//   as the final character of the current one sits in the output register.
module ip_address_to_text (
  input  wire logic   clk,
  input  wire logic   rst,
  ipa2t_in_if.sink    in_ch,
  ipa2t_out_if.source out_ch
);
  import ipa2t_pkg::*;

  char_beat_t beat;
  logic       step_en;
  logic       out_valid;
  logic [6:0] out_code;
  logic       out_last;

  // sequencer advances whenever the output register can take a beat
  assign step_en = !out_valid || out_ch.ready;

  ipa2t_fmt u_fmt (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .step_en (step_en),
    .beat    (beat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && beat.valid) begin
      out_code <= beat.code;
      out_last <= beat.last;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = out_code;
  assign out_ch.last      = out_last;

endmodule

`default_nettype wire

// File: rtl/ipa2t_dd.sv
`default_nettype none

// Bit-serial binary to BCD (shift and add-3), three digits for one octet
module ipa2t_dd (
  input  wire logic                clk,
  input  wire ipa2t_pkg::dd_ctrl_t ctrl,
  output logic [3:0]               digit
);
  import ipa2t_pkg::*;

  logic [11:0] bcd;
  logic [11:0] base;
  logic [11:0] adj;
  logic [11:0] bcd_next;

  // add 3 to every digit of 5 or more, then shift the new bit in
  always_comb begin
    base = ctrl.first ? 12'd0 : bcd;
    for (int i = 0; i < 3; i++) begin
      adj[i*4 +: 4] = (base[i*4 +: 4] >= 4'd5) ? base[i*4 +: 4] + 4'd3 : base[i*4 +: 4];
    end
    if (ctrl.shift) begin
      bcd_next = {adj[10:0], ctrl.bit_in};
    end else if (ctrl.next_digit) begin
      bcd_next = {bcd[7:0], 4'd0};
    end else begin
      bcd_next = bcd;
    end
  end

  always_ff @(posedge clk) begin
    bcd <= bcd_next;
  end

  assign digit = bcd[11:8];

endmodule

`default_nettype wire

// File: rtl/ipa2t_fmt.sv
`default_nettype none

// Text sequencer: walks the address a nibble (IPv6) or a bit (IPv4) at a time
module ipa2t_fmt (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ipa2t_in_if.sink                   in_ch,
  input  wire logic                  step_en,
  output ipa2t_pkg::char_beat_t      beat
);
  import ipa2t_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [V6_WIDTH-1:0]   sh6;
  logic [V4_WIDTH-1:0]   sh4;
  logic [2:0]            widx;
  logic [1:0]            nidx;
  logic [2:0]            bcnt;
  logic [1:0]            oidx;
  logic                  started;
  logic                  elided;
  dd_ctrl_t              dd_ctrl;
  logic [3:0]            dec_digit;

  logic [15:0] word;
  logic        word_zero;
  logic        next_zero;
  logic [3:0]  nib;
  logic        run_start;
  logic        accept;

  assign word      = sh6[V6_WIDTH-1 -: 16];
  assign word_zero = (word == 16'd0);
  assign next_zero = (sh6[V6_WIDTH-17 -: 16] == 16'd0);
  assign nib       = sh6[V6_WIDTH-1 -: 4];
  assign run_start = word_zero && !elided;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  ipa2t_dd u_dd (
    .clk   (clk),
    .ctrl  (dd_ctrl),
    .digit (dec_digit)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = in_ch.is_ipv6 ? S_V6_WORD : S_V4_CONV;
        end
      end
      S_V6_WORD: begin
        state_next = run_start ? S_V6_SKIP : S_V6_NIB;
      end
      S_V6_SKIP: begin
        if (widx == 3'd7) begin
          state_next = S_IDLE;
        end else if (!next_zero) begin
          state_next = S_V6_WORD;
        end
      end
      S_V6_NIB: begin
        if (nidx == 2'd3) begin
          state_next = (widx == 3'd7) ? S_IDLE : S_V6_WORD;
        end
      end
      S_V4_CONV: begin
        if (bcnt == 3'd7) begin
          state_next = S_V4_DIG;
        end
      end
      S_V4_DIG: begin
        if (nidx == 2'd2) begin
          state_next = (oidx == 2'd3) ? S_IDLE : S_V4_DOT;
        end
      end
      S_V4_DOT: begin
        state_next = S_V4_CONV;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // beat and BCD unit control
  always_comb begin
    beat    = '0;
    dd_ctrl = '0;
    unique case (state)
      S_IDLE: begin
      end
      S_V6_WORD: begin
        beat.valid = run_start || (widx != 3'd0);
        beat.code  = CHAR_COLON;
      end
      S_V6_SKIP: begin
        // run reaching the end closes with a second colon
        beat.valid = (widx == 3'd7);
        beat.code  = CHAR_COLON;
        beat.last  = 1'b1;
      end
      S_V6_NIB: begin
        beat.valid = (nib != 4'd0) || started || (nidx == 2'd3);
        beat.code  = hex_char(nib);
        beat.last  = (nidx == 2'd3) && (widx == 3'd7);
      end
      S_V4_CONV: begin
        dd_ctrl.shift  = step_en;
        dd_ctrl.first  = (bcnt == 3'd0);
        dd_ctrl.bit_in = sh4[V4_WIDTH-1];
      end
      S_V4_DIG: begin
        beat.valid         = (dec_digit != 4'd0) || started || (nidx == 2'd2);
        beat.code          = CHAR_ZERO + {3'b000, dec_digit};
        beat.last          = (nidx == 2'd2) && (oidx == 2'd3);
        dd_ctrl.next_digit = step_en;
      end
      S_V4_DOT: begin
        beat.valid = 1'b1;
        beat.code  = CHAR_DOT;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (accept || step_en) begin
      state <= state_next;
    end
  end

  // shift registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      widx    <= 3'd0;
      nidx    <= 2'd0;
      bcnt    <= 3'd0;
      oidx    <= 2'd0;
      started <= 1'b0;
      elided  <= 1'b0;
    end else if (accept) begin
      sh6     <= {in_ch.addr_hi, in_ch.addr_lo};
      sh4     <= in_ch.ipv4_addr;
      widx    <= 3'd0;
      nidx    <= 2'd0;
      bcnt    <= 3'd0;
      oidx    <= 2'd0;
      started <= 1'b0;
      elided  <= 1'b0;
    end else if (step_en) begin
      unique case (state)
        S_V6_WORD: begin
          if (run_start) begin
            elided <= 1'b1;
          end
        end
        S_V6_SKIP: begin
          if (widx != 3'd7) begin
            sh6  <= {sh6[V6_WIDTH-17:0], 16'd0};
            widx <= widx + 3'd1;
          end
        end
        S_V6_NIB: begin
          sh6  <= {sh6[V6_WIDTH-5:0], 4'd0};
          nidx <= nidx + 2'd1;
          if (nidx == 2'd3) begin
            widx    <= widx + 3'd1;
            started <= 1'b0;
          end else if (beat.valid) begin
            started <= 1'b1;
          end
        end
        S_V4_CONV: begin
          sh4  <= {sh4[V4_WIDTH-2:0], 1'b0};
          bcnt <= bcnt + 3'd1;
        end
        S_V4_DIG: begin
          if (nidx == 2'd2) begin
            nidx    <= 2'd0;
            started <= 1'b0;
            oidx    <= oidx + 2'd1;
          end else begin
            nidx <= nidx + 2'd1;
            if (beat.valid) begin
              started <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // final beat ends the item
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (step_en && beat.valid && beat.last) |=> (state == S_IDLE))
    else $error("sequencer kept running after the final character");

  // once the zero run is taken it stays taken for the rest of the item
  a_elided_holds: assert property (@(posedge clk) disable iff (rst)
    (elided && state != S_IDLE) |=> (elided || state == S_IDLE))
    else $error("zero-run flag dropped inside an item");

  // skipping words only happens inside the compressed run
  a_skip_elided: assert property (@(posedge clk) disable iff (rst)
    (state == S_V6_SKIP) |-> elided)
    else $error("word skip outside the compressed run");

  // the units digit of an octet is always printed
  a_units_shown: assert property (@(posedge clk) disable iff (rst)
    (state == S_V4_DIG && nidx == 2'd2) |-> beat.valid)
    else $error("units digit suppressed");

endmodule

`default_nettype wire
